// ===== hdl/power_law_log_fit_assert.svh =====
// Assertion macros shared by the power law fit checker.
`ifndef POWER_LAW_LOG_FIT_ASSERT_SVH
`define POWER_LAW_LOG_FIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define PLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/plf_pkg.sv =====
// Shared types, constants and command encodings of the power law fit block.
package plf_pkg;

  localparam int DEFAULT_MAX_POINTS = 256;
  localparam int LOG_W = 25;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_DEN    = 2'd1,
    ST_ZERO_SAMPLE = 2'd2
  } fit_status_t;

  typedef enum logic [2:0] {
    MP_N_SXX  = 3'd0,
    MP_SX_SX  = 3'd1,
    MP_N_SXY  = 3'd2,
    MP_SX_SY  = 3'd3,
    MP_SY_SXX = 3'd4,
    MP_SX_SXY = 3'd5
  } mul_pair_t;

  typedef enum logic {
    LS_X = 1'b0,
    LS_Y = 1'b1
  } log_sel_t;

  typedef enum logic {
    DS_SLOPE = 1'b0,
    DS_ICPT  = 1'b1
  } div_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MARK_BAD,
    OP_LOG_LOAD,
    OP_NORM,
    OP_SQUARE,
    OP_SCALE_MUL,
    OP_SCALE_FIN,
    OP_ACC_XY,
    OP_ACC_XX,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_MUL_FIN,
    OP_MUL_STORE,
    OP_DIV_LOAD,
    OP_DIV_PREP,
    OP_DIV_STEP,
    OP_DIV_FIN,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_LOG_LOAD,
    S_NORM,
    S_SQUARE,
    S_SCALE_MUL,
    S_SCALE_FIN,
    S_ACC_XY,
    S_ACC_XX,
    S_CHECK_LAST,
    S_MUL_LOAD,
    S_MUL_STEP,
    S_MUL_FIN,
    S_MUL_STORE,
    S_DEN_CHECK,
    S_DIV_LOAD,
    S_DIV_PREP,
    S_DIV_STEP,
    S_DIV_FIN,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t      op;
    log_sel_t    which;
    mul_pair_t   msel;
    div_sel_t    dsel;
    fit_status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_bad;
    logic full;
    logic last;
    logic bad_flag;
    logic norm_done;
    logic den_bad;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hdl/power_law_log_fit.sv =====
// Top level of the log-log least squares power law fit block.
//
// The block fits y = exp(a) * x^b over a run of (x, y) samples. Each sample
// transfer carries an integer x and a Q8.16 y; the block takes ln x and ln y
// in Q.20 and accumulates the count and the sums of ln x, ln y, ln x*ln y and
// (ln x)^2. The transfer marked by in_tlast closes the run: one result
// transfer follows with slope b and intercept a in saturated Q16.16, the
// number of samples used, and a status (ok, zero denominator, or a zero
// sample seen, in which case slope and intercept are zero). Samples with a
// zero x or y are not accumulated; once MAX_POINTS samples are held, further
// samples are dropped. One sample is handled at a time; its handling time
// grows with the leading zeros of x and y, set by the shared logarithm unit
// (a normalizing shift of one bit per cycle and 24 squaring steps per log).
// Closing a run then runs the bit-serial 64 by 64 multiplier (six products)
// and the restoring divider (two quotients). A finished result waits in its
// output register, and the next sample is accepted meanwhile.
module power_law_log_fit #(
  parameter int MAX_POINTS  = plf_pkg::DEFAULT_MAX_POINTS,
  parameter int CNT_W       = $clog2(MAX_POINTS + 1),
  parameter int OUT_TDATA_W = ((64 + CNT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [39:0]            in_tdata,   // x_value[15:0], y_value[39:16]
  input  logic                   in_tlast,   // last_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slope, intercept, points_used, zero pad
  output logic [1:0]             out_tuser   // fit_status
);
  import plf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [31:0]      slope, intercept;
  logic [CNT_W-1:0] points_used;
  logic [1:0]       fit_status;

  plf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_x_value      (in_tdata[15:0]),
    .in_y_value      (in_tdata[39:16]),
    .in_last_sample  (in_tlast),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_slope       (slope),
    .out_intercept   (intercept),
    .out_points_used (points_used),
    .out_fit_status  (fit_status)
  );

  // Pack the result fields from the lowest bit up and pad with zeros.
  assign out_tdata = OUT_TDATA_W'({points_used, intercept, slope});
  assign out_tuser = fit_status;

endmodule

// ===== hdl/plf_ctrl.sv =====
// Sequencer that steps the datapath through logs, accumulation and the fit.
module plf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  plf_pkg::dp_sts_t  sts,
  output plf_pkg::dp_cmd_t  cmd
);
  import plf_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  log_sel_t    which_r, which_nxt;
  mul_pair_t   msel_r, msel_nxt;
  div_sel_t    dsel_r, dsel_nxt;
  fit_status_t fstat_r, fstat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      which_r <= LS_X;
      msel_r  <= MP_N_SXX;
      dsel_r  <= DS_SLOPE;
      fstat_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      which_r <= which_nxt;
      msel_r  <= msel_nxt;
      dsel_r  <= dsel_nxt;
      fstat_r <= fstat_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    which_nxt  = which_r;
    msel_nxt   = msel_r;
    dsel_nxt   = dsel_r;
    fstat_nxt  = fstat_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NONE;
    cmd.which  = which_r;
    cmd.msel   = msel_r;
    cmd.dsel   = dsel_r;
    cmd.status = fstat_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.sample_bad) begin
          cmd.op    = OP_MARK_BAD;
          state_nxt = S_CHECK_LAST;
        end else if (sts.full) begin
          state_nxt = S_CHECK_LAST;
        end else begin
          which_nxt = LS_X;
          state_nxt = S_LOG_LOAD;
        end
      end
      S_LOG_LOAD: begin
        cmd.op    = OP_LOG_LOAD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cnt_nxt   = 7'd23;
          state_nxt = S_SQUARE;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SQUARE: begin
        cmd.op = OP_SQUARE;
        if (cnt_r == '0) state_nxt = S_SCALE_MUL;
        else cnt_nxt = cnt_r - 7'd1;
      end
      S_SCALE_MUL: begin
        cmd.op    = OP_SCALE_MUL;
        state_nxt = S_SCALE_FIN;
      end
      S_SCALE_FIN: begin
        cmd.op = OP_SCALE_FIN;
        if (which_r == LS_X) begin
          which_nxt = LS_Y;
          state_nxt = S_LOG_LOAD;
        end else begin
          state_nxt = S_ACC_XY;
        end
      end
      S_ACC_XY: begin
        cmd.op    = OP_ACC_XY;
        state_nxt = S_ACC_XX;
      end
      S_ACC_XX: begin
        cmd.op    = OP_ACC_XX;
        state_nxt = S_CHECK_LAST;
      end
      S_CHECK_LAST: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (sts.bad_flag) begin
          fstat_nxt = ST_ZERO_SAMPLE;
          state_nxt = S_RESULT;
        end else begin
          msel_nxt  = MP_N_SXX;
          state_nxt = S_MUL_LOAD;
        end
      end
      S_MUL_LOAD: begin
        cmd.op    = OP_MUL_LOAD;
        cnt_nxt   = 7'd63;
        state_nxt = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        cmd.op = OP_MUL_STEP;
        if (cnt_r == '0) state_nxt = S_MUL_FIN;
        else cnt_nxt = cnt_r - 7'd1;
      end
      S_MUL_FIN: begin
        cmd.op    = OP_MUL_FIN;
        state_nxt = S_MUL_STORE;
      end
      S_MUL_STORE: begin
        cmd.op = OP_MUL_STORE;
        if (msel_r == MP_SX_SX) begin
          state_nxt = S_DEN_CHECK;
        end else if (msel_r == MP_SX_SXY) begin
          dsel_nxt  = DS_SLOPE;
          state_nxt = S_DIV_LOAD;
        end else begin
          msel_nxt  = mul_pair_t'(msel_r + 3'd1);
          state_nxt = S_MUL_LOAD;
        end
      end
      S_DEN_CHECK: begin
        if (sts.den_bad) begin
          fstat_nxt = ST_ZERO_DEN;
          state_nxt = S_RESULT;
        end else begin
          msel_nxt  = MP_N_SXY;
          state_nxt = S_MUL_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd.op    = OP_DIV_LOAD;
        state_nxt = S_DIV_PREP;
      end
      S_DIV_PREP: begin
        cmd.op    = OP_DIV_PREP;
        cnt_nxt   = 7'd127;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = S_DIV_FIN;
        else cnt_nxt = cnt_r - 7'd1;
      end
      S_DIV_FIN: begin
        cmd.op = OP_DIV_FIN;
        if (dsel_r == DS_SLOPE) begin
          dsel_nxt  = DS_ICPT;
          state_nxt = S_DIV_LOAD;
        end else begin
          fstat_nxt = ST_OK;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/plf_dp.sv =====
// Datapath: log unit, accumulators, serial multiplier, divider, result register.
module plf_dp #(
  parameter int MAX_POINTS = plf_pkg::DEFAULT_MAX_POINTS,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [15:0]             in_x_value,
  input  logic [23:0]             in_y_value,
  input  logic                    in_last_sample,
  input  plf_pkg::dp_cmd_t        cmd,
  output plf_pkg::dp_sts_t        sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_slope,
  output logic [31:0]             out_intercept,
  output logic [CNT_W-1:0]        out_points_used,
  output logic [1:0]              out_fit_status
);
  import plf_pkg::*;

  localparam int SX_W  = LOG_W + CNT_W - 1;
  localparam int SY_W  = SX_W + 1;
  localparam int SXY_W = 2 * LOG_W + CNT_W - 3;
  localparam int SXX_W = SXY_W - 1;
  localparam int FB_Y  = 16;

  // captured sample
  logic [15:0] x_r;
  logic [23:0] y_r;
  logic        last_r;

  // log unit
  logic [31:0] m_r;
  logic [4:0]  k_r;
  logic [23:0] frac_r;
  logic [62:0] sprod_r;
  logic        sneg_r;
  logic signed [LOG_W-1:0] lx_r, ly_r;

  // accumulators
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SX_W-1:0]  sx_r;
  logic signed [SY_W-1:0]  sy_r;
  logic signed [SXY_W-1:0] sxy_r;
  logic signed [SXX_W-1:0] sxx_r;
  logic                    bad_r;

  // multiplier and fit terms
  logic [63:0]  ma_r, mb_r;
  logic         mneg_r;
  logic [127:0] prod_r, t1_r, den_r, nb_r, na_r;

  // divider
  logic [127:0] num_r, dd_r, rem_r, quo_r;
  logic         dneg_r;
  logic [31:0]  slope_r, icpt_r;

  logic        out_valid_r;
  logic [31:0] out_slope_r, out_icpt_r;
  logic [CNT_W-1:0] out_cnt_r;
  fit_status_t out_stat_r;

  // combinational helpers
  logic [63:0]  sq;
  logic [32:0]  mn;
  logic signed [6:0]  lint;
  logic signed [30:0] l_val;
  logic [30:0]  l_mag;
  logic [62:0]  rnd;
  logic [26:0]  r_mag, l_res;
  logic signed [2*LOG_W-1:0] pxy, pxx;
  logic signed [63:0] op_a, op_b;
  logic [63:0]  a_mag, b_mag;
  logic [127:0] diff, numer, dn, rs, lim_w;
  logic         ge, sat;
  logic [63:0]  lim, v, vres;

  always_comb begin
    sq    = 64'(m_r) * 64'(m_r);
    mn    = sq[63:31];
    lint  = signed'(7'(k_r)) - ((cmd.which == LS_Y) ? 7'(FB_Y) : 7'd0);
    l_val = {lint, frac_r};
    l_mag = l_val[30] ? 31'(-l_val) : 31'(l_val);
    rnd   = sprod_r + (63'(1) << 35);
    r_mag = rnd[62:36];
    l_res = sneg_r ? 27'(-r_mag) : r_mag;
    pxy   = lx_r * ly_r;
    pxx   = lx_r * lx_r;

    op_a = '0;
    op_b = '0;
    unique case (cmd.msel)
      MP_N_SXX:  begin op_a = 64'(cnt_r); op_b = 64'(sxx_r); end
      MP_SX_SX:  begin op_a = 64'(sx_r);  op_b = 64'(sx_r);  end
      MP_N_SXY:  begin op_a = 64'(cnt_r); op_b = 64'(sxy_r); end
      MP_SX_SY:  begin op_a = 64'(sx_r);  op_b = 64'(sy_r);  end
      MP_SY_SXX: begin op_a = 64'(sy_r);  op_b = 64'(sxx_r); end
      MP_SX_SXY: begin op_a = 64'(sx_r);  op_b = 64'(sxy_r); end
      default:   begin op_a = '0; op_b = '0; end
    endcase
    a_mag = op_a[63] ? 64'(-op_a) : 64'(op_a);
    b_mag = op_b[63] ? 64'(-op_b) : 64'(op_b);
    diff  = t1_r - prod_r;

    numer = (cmd.dsel == DS_ICPT) ? na_r : nb_r;
    dn    = (cmd.dsel == DS_ICPT) ? (den_r << 4) : den_r;
    rs    = {rem_r[126:0], num_r[127]};
    ge    = (rs >= dd_r);

    lim   = dneg_r ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    lim_w = 128'(lim);
    sat   = (quo_r > lim_w);
    v     = sat ? lim : quo_r[63:0];
    vres  = dneg_r ? 64'(-v) : v;
  end

  // State that reset clears, plus the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxy_r       <= '0;
      sxx_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_RESULT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_MARK_BAD: bad_r <= 1'b1;
        OP_ACC_XY:   sxy_r <= sxy_r + SXY_W'(pxy);
        OP_ACC_XX: begin
          sxx_r <= sxx_r + SXX_W'(pxx);
          sx_r  <= sx_r + SX_W'(lx_r);
          sy_r  <= sy_r + SY_W'(ly_r);
          cnt_r <= cnt_r + 1'b1;
        end
        OP_RESULT: begin
          cnt_r <= '0;
          sx_r  <= '0;
          sy_r  <= '0;
          sxy_r <= '0;
          sxx_r <= '0;
          bad_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        x_r    <= in_x_value;
        y_r    <= in_y_value;
        last_r <= in_last_sample;
      end
      OP_LOG_LOAD: begin
        m_r    <= (cmd.which == LS_Y) ? 32'(y_r) : 32'(x_r);
        k_r    <= 5'd31;
        frac_r <= '0;
      end
      OP_NORM: begin
        m_r <= m_r << 1;
        k_r <= k_r - 5'd1;
      end
      OP_SQUARE: begin
        if (mn[32]) begin
          m_r    <= mn[32:1];
          frac_r <= {frac_r[22:0], 1'b1};
        end else begin
          m_r    <= mn[31:0];
          frac_r <= {frac_r[22:0], 1'b0};
        end
      end
      OP_SCALE_MUL: begin
        sneg_r  <= l_val[30];
        sprod_r <= 63'(l_mag) * 63'(LN2_Q32);
      end
      OP_SCALE_FIN: begin
        if (cmd.which == LS_Y) ly_r <= LOG_W'(l_res);
        else lx_r <= LOG_W'(l_res);
      end
      OP_MUL_LOAD: begin
        ma_r   <= a_mag;
        mb_r   <= b_mag;
        mneg_r <= op_a[63] ^ op_b[63];
        prod_r <= '0;
      end
      OP_MUL_STEP: begin
        prod_r <= {prod_r[126:0], 1'b0} + (mb_r[63] ? 128'(ma_r) : 128'd0);
        mb_r   <= mb_r << 1;
      end
      OP_MUL_FIN: prod_r <= mneg_r ? 128'(-prod_r) : prod_r;
      OP_MUL_STORE: begin
        case (cmd.msel) inside
          MP_N_SXX, MP_N_SXY, MP_SY_SXX: t1_r <= prod_r;
          MP_SX_SX:  den_r <= diff;
          MP_SX_SY:  nb_r  <= diff << 16;
          MP_SX_SXY: na_r  <= diff;
          default: ;
        endcase
      end
      OP_DIV_LOAD: begin
        dneg_r <= numer[127];
        num_r  <= numer[127] ? 128'(-numer) : numer;
        dd_r   <= dn;
      end
      OP_DIV_PREP: begin
        num_r <= (num_r << 1) + dd_r;
        dd_r  <= dd_r << 1;
        rem_r <= '0;
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? (rs - dd_r) : rs;
        quo_r <= {quo_r[126:0], ge};
        num_r <= num_r << 1;
      end
      OP_DIV_FIN: begin
        if (cmd.dsel == DS_ICPT) icpt_r <= vres[31:0];
        else slope_r <= vres[31:0];
      end
      OP_RESULT: begin
        out_slope_r <= (cmd.status == ST_OK) ? slope_r : 32'd0;
        out_icpt_r  <= (cmd.status == ST_OK) ? icpt_r : 32'd0;
        out_cnt_r   <= cnt_r;
        out_stat_r  <= cmd.status;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.sample_bad = (x_r == '0) || (y_r == '0);
    sts.full       = (cnt_r >= CNT_W'(MAX_POINTS));
    sts.last       = last_r;
    sts.bad_flag   = bad_r;
    sts.norm_done  = m_r[31];
    sts.den_bad    = (den_r == '0) || den_r[127];
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_slope       = out_slope_r;
  assign out_intercept   = out_icpt_r;
  assign out_points_used = out_cnt_r;
  assign out_fit_status  = out_stat_r;

endmodule

// ===== hdl/plf_checker.sv =====
// Port-level checker for the power law fit block and its bind.
`include "power_law_log_fit_assert.svh"

module plf_checker #(
  parameter int MAX_POINTS  = plf_pkg::DEFAULT_MAX_POINTS,
  parameter int CNT_W       = $clog2(MAX_POINTS + 1),
  parameter int OUT_TDATA_W = ((64 + CNT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser
);
  import plf_pkg::*;

  // A pending result stays offered until it is taken.
  `PLF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")

  // A failed fit reports zero slope and intercept.
  `PLF_ASSERT_NOW(a_fail_zero, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata[63:0] == 64'd0, "failed fit carries nonzero terms")

  // Samples are worked one at a time, so ready drops after each transfer.
  `PLF_ASSERT_NEXT(a_one_sample, clk, rst_n, in_tvalid && in_tready, !in_tready, "second sample taken while busy")

endmodule

bind power_law_log_fit plf_checker #(.MAX_POINTS(MAX_POINTS)) u_plf_checker (.*);
